/* design/zsi_pkg.sv */
package zsi_pkg;

    localparam int MAX_STOPS = 16;
    localparam int IDX_W     = $clog2(MAX_STOPS);
    localparam int CNT_W     = $clog2(MAX_STOPS + 1);
    localparam int ZOOM_W    = 24;
    localparam int VAL_W     = 32;
    localparam int EXP_TBITS = 24;
    localparam int EXP_FRAC  = 36;

    // Configuration register indexes.
    localparam logic [1:0] CFG_BASE_LOG2  = 2'd0;
    localparam logic [1:0] CFG_STOP_COUNT = 2'd1;
    localparam logic [1:0] CFG_VALUE_MODE = 2'd2;

    // Input item kinds.
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_EVAL = 1'b1;

    // Result case codes.
    localparam logic [2:0] CASE_DEFAULT = 3'd0;
    localparam logic [2:0] CASE_BELOW   = 3'd1;
    localparam logic [2:0] CASE_ABOVE   = 3'd2;
    localparam logic [2:0] CASE_INTERP  = 3'd3;
    localparam logic [2:0] CASE_NOSEG   = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIRST,
        ST_LAST,
        ST_SCAN,
        ST_GETA,
        ST_DIV,
        ST_MULX,
        ST_MULY,
        ST_EXP,
        ST_EXPF,
        ST_TSET,
        ST_LERP,
        ST_LADD,
        ST_OUT
    } zsi_state_t;

    typedef logic [EXP_TBITS-1:0][31:0] fac_tab_t;

    // Floor square root of a 64-bit value, one result bit per step.
    function automatic logic [31:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = '0;
        b = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r[31:0];
    endfunction

    // Factors 2^(-2^-k), k = 1..EXP_TBITS, in Q0.32, by repeated square roots of 0.5.
    function automatic fac_tab_t build_fac();
        fac_tab_t    tab;
        logic [31:0] f;
        f = 32'h8000_0000;
        for (int k = 0; k < EXP_TBITS; k++) begin
            f = isqrt64({f, 32'h0});
            tab[k] = f;
        end
        return tab;
    endfunction

    localparam fac_tab_t EXP_FAC = build_fac();

endpackage

/* design/zoom_stop_interpolator_core.sv */
// Channel   Direction  Payload
// s_*       in         tdata: stop_index, stop_zoom, stop_value, zoom, default_value;
//                      tuser: action
// m_*       out        tdata: result_value; tuser: case_taken
// cfg_*     in         write enable, register index, write data
//
// A load transfer yields no result. An evaluation with no stops in use goes straight to the
// output; the longest one runs a scan of the stop table at one read per cycle, a 31-step
// shared restoring divider, two 24-step exp2 runs on the shared multiplier, a second divide
// and one to four multiply-add passes. Reset (aresetn low, synchronous) clears the
// sequencer, the configuration registers and the result valid; the stop table is not
// cleared. A stalled result holds in the output register while the next item is accepted;
// the sequencer then waits to hand it over.
module zoom_stop_interpolator_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [3:0] stop_index, [27:4] stop_zoom, [59:28] stop_value, [83:60] zoom,
    // [115:84] default_value, [119:116] zero
    input  logic [119:0] s_tdata,
    // [0] action
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [31:0] result_value
    output logic [31:0]  m_tdata,
    // [2:0] case_taken
    output logic [2:0]   m_tuser,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [23:0]  cfg_wdata
);
    import zsi_pkg::*;

    // Stop table.
    logic signed [ZOOM_W-1:0] zoom_mem [MAX_STOPS];
    logic        [VAL_W-1:0]  val_mem  [MAX_STOPS];
    logic signed [ZOOM_W-1:0] rd_zoom_reg;
    logic        [VAL_W-1:0]  rd_val_reg;

    zsi_state_t state_reg, state_next;

    logic signed [23:0] base_log2_reg;
    logic [4:0]         stop_count_reg;
    logic               value_mode_reg;

    logic signed [ZOOM_W-1:0] zoom_reg, zoom_next;
    logic signed [ZOOM_W-1:0] za_reg, za_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic [24:0]              dz_reg, dz_next;
    logic [24:0]              span_reg, span_next;
    logic [31:0]              va_reg, va_next;
    logic [31:0]              vb_reg, vb_next;
    logic [31:0]              res_reg, res_next;
    logic [2:0]               case_reg, case_next;
    logic [33:0]              div_rem_reg, div_rem_next;
    logic [33:0]              div_den_reg, div_den_next;
    logic [31:0]              div_q_reg, div_q_next;
    logic [4:0]               div_cnt_reg, div_cnt_next;
    logic                     div_exp_reg, div_exp_next;
    logic [31:0]              lin_reg, lin_next;
    logic [31:0]              t_reg, t_next;
    logic [47:0]              x_reg, x_next;
    logic [47:0]              y_reg, y_next;
    logic [47:0]              exp_u_reg, exp_u_next;
    logic [32:0]              acc_reg, acc_next;
    logic [4:0]               k_reg, k_next;
    logic                     exp_phase_reg, exp_phase_next;
    logic [32:0]              e1_reg, e1_next;
    logic [32:0]              e2_reg, e2_next;
    logic [1:0]               ch_reg, ch_next;
    logic signed [66:0]       prod_reg, prod_next;

    logic        m_valid_reg, m_valid_next;
    logic [31:0] m_data_reg, m_data_next;
    logic [2:0]  m_case_reg, m_case_next;

    // Shared multiplier.
    logic signed [33:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [66:0] mul_p;
    assign mul_p = mul_a * mul_b;

    logic                     s_acc;
    logic [CNT_W-1:0]         n_used;
    logic [IDX_W-1:0]         n_last;
    logic [23:0]              lmag;
    logic                     l_pos;
    logic                     l_zero;
    logic                     out_free;
    logic [34:0]              div_r2;
    logic                     div_ge;
    logic [5:0]               ebit_idx;
    logic [11:0]              exp_ip;
    logic signed [33:0]       num_s;
    logic [33:0]              den_u;
    logic [32:0]              d33;
    logic [8:0]               d9;
    logic [7:0]               va_b;
    logic [7:0]               vb_b;
    logic [ZOOM_W-1:0]        in_zoom;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign in_zoom  = s_tdata[83:60];
    assign n_used   = (stop_count_reg > 5'(MAX_STOPS)) ? CNT_W'(MAX_STOPS)
                                                       : CNT_W'(stop_count_reg);
    assign n_last   = IDX_W'(n_used - CNT_W'(1));
    assign l_zero   = (base_log2_reg == 24'sd0);
    assign l_pos    = !base_log2_reg[23] && !l_zero;
    assign lmag     = base_log2_reg[23] ? 24'(-base_log2_reg) : 24'(base_log2_reg);
    assign out_free = !m_valid_reg || m_tready;

    assign div_r2   = {div_rem_reg, 1'b0};
    assign div_ge   = (div_r2 >= {1'b0, div_den_reg});
    assign ebit_idx = 6'd35 - {1'b0, k_reg};
    assign exp_ip   = exp_u_reg[47:EXP_FRAC];

    assign va_b = va_reg[{ch_reg, 3'b000} +: 8];
    assign vb_b = vb_reg[{ch_reg, 3'b000} +: 8];
    assign d33  = {vb_reg[31], vb_reg} - {va_reg[31], va_reg};
    assign d9   = {1'b0, vb_b} - {1'b0, va_b};

    // Numerator and denominator of the exponential fraction.
    always_comb begin
        if (l_pos) begin
            num_s = $signed({1'b0, e1_reg}) - $signed({1'b0, e2_reg});
        end else begin
            num_s = $signed(34'h1_0000_0000) - $signed({1'b0, e1_reg});
        end
        den_u = 34'h1_0000_0000 - {1'b0, e2_reg};
    end

    // Multiplier operand selection.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_MULX: begin
                mul_a = 34'(lmag);
                mul_b = 33'(dz_reg);
            end
            ST_MULY: begin
                mul_a = 34'(lmag);
                mul_b = 33'(span_reg);
            end
            ST_EXP: begin
                mul_a = 34'(acc_reg);
                mul_b = {1'b0, EXP_FAC[k_reg]};
            end
            ST_LERP: begin
                if (value_mode_reg) begin
                    mul_a = {{25{d9[8]}}, d9};
                end else begin
                    mul_a = {d33[32], d33};
                end
                mul_b = {1'b0, t_reg};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc && s_tuser[0] == ACT_EVAL) begin
                    state_next = (n_used == '0) ? ST_OUT : ST_FIRST;
                end
            end
            ST_FIRST: state_next = (zoom_reg <= rd_zoom_reg) ? ST_OUT : ST_LAST;
            ST_LAST:  state_next = (zoom_reg > rd_zoom_reg) ? ST_OUT : ST_SCAN;
            ST_SCAN: begin
                if (za_reg <= zoom_reg && zoom_reg < rd_zoom_reg) begin
                    state_next = ST_GETA;
                end else if (idx_reg == n_last) begin
                    state_next = ST_OUT;
                end
            end
            ST_GETA: state_next = ST_DIV;
            ST_DIV: begin
                if (div_cnt_reg == 5'd30) begin
                    if (div_exp_reg || l_zero) begin
                        state_next = ST_LERP;
                    end else begin
                        state_next = ST_MULX;
                    end
                end
            end
            ST_MULX: state_next = ST_MULY;
            ST_MULY: state_next = ST_EXP;
            ST_EXP:  state_next = (k_reg == 5'(EXP_TBITS - 1)) ? ST_EXPF : ST_EXP;
            ST_EXPF: state_next = exp_phase_reg ? ST_TSET : ST_EXP;
            ST_TSET: begin
                if (den_u == '0 || num_s >= $signed(den_u)) begin
                    state_next = ST_LERP;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_LERP: state_next = ST_LADD;
            ST_LADD: state_next = (value_mode_reg && ch_reg != 2'd3) ? ST_LERP : ST_OUT;
            ST_OUT:  state_next = out_free ? ST_IDLE : ST_OUT;
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and output register updates.
    always_comb begin
        zoom_next      = zoom_reg;
        za_next        = za_reg;
        idx_next       = idx_reg;
        dz_next        = dz_reg;
        span_next      = span_reg;
        va_next        = va_reg;
        vb_next        = vb_reg;
        res_next       = res_reg;
        case_next      = case_reg;
        div_rem_next   = div_rem_reg;
        div_den_next   = div_den_reg;
        div_q_next     = div_q_reg;
        div_cnt_next   = div_cnt_reg;
        div_exp_next   = div_exp_reg;
        lin_next       = lin_reg;
        t_next         = t_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        exp_u_next     = exp_u_reg;
        acc_next       = acc_reg;
        k_next         = k_reg;
        exp_phase_next = exp_phase_reg;
        e1_next        = e1_reg;
        e2_next        = e2_reg;
        ch_next        = ch_reg;
        prod_next      = prod_reg;
        m_valid_next   = m_tready ? 1'b0 : m_valid_reg;
        m_data_next    = m_data_reg;
        m_case_next    = m_case_reg;

        unique case (state_reg)
            ST_IDLE: begin
                zoom_next = in_zoom;
                res_next  = s_tdata[115:84];
                case_next = CASE_DEFAULT;
                idx_next  = '0;
            end
            ST_FIRST: begin
                za_next  = rd_zoom_reg;
                res_next = rd_val_reg;
                if (zoom_reg <= rd_zoom_reg) begin
                    case_next = CASE_BELOW;
                end else begin
                    idx_next = n_last;
                end
            end
            ST_LAST: begin
                res_next = rd_val_reg;
                if (zoom_reg > rd_zoom_reg) begin
                    case_next = CASE_ABOVE;
                end else begin
                    case_next = CASE_NOSEG;
                    idx_next  = IDX_W'(1);
                end
            end
            ST_SCAN: begin
                if (za_reg <= zoom_reg && zoom_reg < rd_zoom_reg) begin
                    dz_next   = 25'({zoom_reg[23], zoom_reg} - {za_reg[23], za_reg});
                    span_next = 25'({rd_zoom_reg[23], rd_zoom_reg} - {za_reg[23], za_reg});
                    vb_next   = rd_val_reg;
                    idx_next  = idx_reg - IDX_W'(1);
                end else if (idx_reg != n_last) begin
                    za_next  = rd_zoom_reg;
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_GETA: begin
                va_next      = rd_val_reg;
                div_rem_next = 34'(dz_reg);
                div_den_next = 34'(span_reg);
                div_q_next   = '0;
                div_cnt_next = '0;
                div_exp_next = 1'b0;
            end
            ST_DIV: begin
                div_rem_next = div_ge ? 34'(div_r2 - {1'b0, div_den_reg}) : div_r2[33:0];
                div_q_next   = {div_q_reg[30:0], div_ge};
                div_cnt_next = div_cnt_reg + 5'd1;
                if (div_cnt_reg == 5'd30) begin
                    if (!div_exp_reg) begin
                        lin_next = {div_q_reg[30:0], div_ge};
                    end
                    if (div_exp_reg || l_zero) begin
                        t_next  = {div_q_reg[30:0], div_ge};
                        ch_next = '0;
                    end
                end
            end
            ST_MULX: x_next = mul_p[47:0];
            ST_MULY: begin
                y_next         = mul_p[47:0];
                exp_u_next     = l_pos ? (mul_p[47:0] - x_reg) : x_reg;
                acc_next       = 33'h1_0000_0000;
                k_next         = '0;
                exp_phase_next = 1'b0;
            end
            ST_EXP: begin
                if (exp_u_reg[ebit_idx]) begin
                    acc_next = mul_p[64:32];
                end
                k_next = k_reg + 5'd1;
            end
            ST_EXPF: begin
                if (!exp_phase_reg) begin
                    e1_next = (exp_ip > 12'd32) ? '0 : (acc_reg >> exp_ip);
                end else begin
                    e2_next = (exp_ip > 12'd32) ? '0 : (acc_reg >> exp_ip);
                end
                exp_u_next     = y_reg;
                acc_next       = 33'h1_0000_0000;
                k_next         = '0;
                exp_phase_next = 1'b1;
            end
            ST_TSET: begin
                ch_next = '0;
                if (den_u == '0) begin
                    t_next = lin_reg;
                end else if (num_s >= $signed(den_u)) begin
                    t_next = 32'h8000_0000;
                end else begin
                    div_rem_next = num_s[33] ? '0 : num_s;
                    div_den_next = den_u;
                    div_q_next   = '0;
                    div_cnt_next = '0;
                    div_exp_next = 1'b1;
                end
            end
            ST_LERP: prod_next = mul_p;
            ST_LADD: begin
                if (value_mode_reg) begin
                    res_next[{ch_reg, 3'b000} +: 8] = va_b + prod_reg[38:31];
                end else begin
                    res_next = va_reg + prod_reg[62:31];
                end
                ch_next   = ch_reg + 2'd1;
                case_next = CASE_INTERP;
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    m_case_next  = case_reg;
                end
            end
            default: begin
                zoom_next = zoom_reg;
            end
        endcase
    end

    // Stop table: written by load transfers, read one entry per cycle.
    always_ff @(posedge aclk) begin
        if (s_acc && s_tuser[0] == ACT_LOAD) begin
            zoom_mem[s_tdata[3:0]] <= s_tdata[27:4];
            val_mem[s_tdata[3:0]]  <= s_tdata[59:28];
        end
        rd_zoom_reg <= zoom_mem[idx_next];
        rd_val_reg  <= val_mem[idx_next];
    end

    // Control state and configuration.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_valid_reg    <= 1'b0;
            base_log2_reg  <= '0;
            stop_count_reg <= '0;
            value_mode_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_BASE_LOG2:  base_log2_reg  <= cfg_wdata;
                    CFG_STOP_COUNT: stop_count_reg <= cfg_wdata[4:0];
                    CFG_VALUE_MODE: value_mode_reg <= cfg_wdata[0];
                    default:        value_mode_reg <= value_mode_reg;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        zoom_reg      <= zoom_next;
        za_reg        <= za_next;
        idx_reg       <= idx_next;
        dz_reg        <= dz_next;
        span_reg      <= span_next;
        va_reg        <= va_next;
        vb_reg        <= vb_next;
        res_reg       <= res_next;
        case_reg      <= case_next;
        div_rem_reg   <= div_rem_next;
        div_den_reg   <= div_den_next;
        div_q_reg     <= div_q_next;
        div_cnt_reg   <= div_cnt_next;
        div_exp_reg   <= div_exp_next;
        lin_reg       <= lin_next;
        t_reg         <= t_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        exp_u_reg     <= exp_u_next;
        acc_reg       <= acc_next;
        k_reg         <= k_next;
        exp_phase_reg <= exp_phase_next;
        e1_reg        <= e1_next;
        e2_reg        <= e2_next;
        ch_reg        <= ch_next;
        prod_reg      <= prod_next;
        m_data_reg    <= m_data_next;
        m_case_reg    <= m_case_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_case_reg;

endmodule

/* tb/tb_zoom_stop_interpolator_core.sv */
`default_nettype none

// Self-checking bench for the zoom stop interpolator. Stop loads and lookups are
// streamed in, configuration is changed only while the core is idle, and every
// returned lookup is compared against its given value or a predictor in this module.
module tb_zoom_stop_interpolator_core;
    import zsi_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] value;
        logic [2:0]  code;
    } lookup_t;

    typedef enum logic [1:0] {ROW_CFG, ROW_LOAD, ROW_EVAL} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [1:0]  reg_sel;
        logic [23:0] reg_data;
        logic [3:0]  slot;
        logic [23:0] slot_zoom;
        logic [31:0] slot_value;
        logic [23:0] zoom;
        logic [31:0] dflt;
        bit          typed;
        logic [31:0] typed_value;
        logic [2:0]  typed_code;
    } row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [119:0] s_tdata = '0;
    logic [0:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [31:0]  m_tdata;
    logic [2:0]   m_tuser;
    logic         cfg_we = 1'b0;
    logic [1:0]   cfg_index = '0;
    logic [23:0]  cfg_wdata = '0;

    zoom_stop_interpolator_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // Predictor state: its own copy of the registers and the stop table.
    logic signed [23:0] base_reg = '0;
    logic [4:0]         count_reg = '0;
    logic               mode_reg = 1'b0;
    logic signed [23:0] table_zoom [MAX_STOPS];
    logic [31:0]        table_value [MAX_STOPS];
    longint unsigned    halving_fac [EXP_TBITS];

    lookup_t pending_lookups [$];
    int      mismatches = 0;
    bit      quiet = 1'b0;     // suppresses idling on both sides
    int      sent = 0;

    // Floor square root, one result bit at a time from the top.
    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned r, cand;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            cand = r | (64'd1 << b);
            if (cand * cand <= v) r = cand;
        end
        return r;
    endfunction

    // 2^-u with u carrying 36 fraction bits; the result is Q1.32.
    function automatic longint unsigned pow2_neg(longint unsigned u);
        longint unsigned ip, acc;
        ip = u >> EXP_FRAC;
        acc = 64'd1 << 32;
        if (ip > 32) return 0;
        for (int k = 0; k < EXP_TBITS; k++)
            if (u[EXP_FRAC-1-k]) acc = (acc * halving_fac[k]) >> 32;
        return acc >> ip;
    endfunction

    // Blend fraction in Q1.31 for offset dz inside a segment of length span.
    function automatic longint unsigned blend_fraction(longint dz, longint span);
        longint unsigned lin, lg, x, y;
        longint num, den;
        lin = (longint'(dz) << 31) / span;
        if (base_reg == 0) return lin;
        if (base_reg > 0) begin
            lg = longint'(base_reg);
            x = lg * dz;
            y = lg * span;
            num = longint'(pow2_neg(y - x)) - longint'(pow2_neg(y));
            den = (longint'(1) << 32) - longint'(pow2_neg(y));
        end else begin
            lg = -longint'(base_reg);
            num = (longint'(1) << 32) - longint'(pow2_neg(lg * dz));
            den = (longint'(1) << 32) - longint'(pow2_neg(lg * span));
        end
        if (den <= 0) return lin;
        if (num < 0) num = 0;
        if (num >= den) return 64'd1 << 31;
        return (unsigned'(num) << 31) / unsigned'(den);
    endfunction

    function automatic longint blend(longint a, longint b, longint unsigned t);
        longint p;
        p = (b - a) * longint'(t);
        return a + (p >>> 31);
    endfunction

    function automatic logic [31:0] blend_value(logic [31:0] va, logic [31:0] vb,
                                                longint unsigned t);
        logic [31:0] r;
        longint      q;
        r = '0;
        if (!mode_reg) begin
            q = blend(longint'($signed(va)), longint'($signed(vb)), t);
            r = q[31:0];
        end else begin
            for (int c = 0; c < 4; c++) begin
                q = blend(longint'(va[8*c +: 8]), longint'(vb[8*c +: 8]), t);
                r[8*c +: 8] = q[7:0];
            end
        end
        return r;
    endfunction

    function automatic lookup_t predict_lookup(logic signed [23:0] z, logic [31:0] dflt);
        lookup_t         res;
        int              n;
        logic signed [23:0] za, zb;
        longint unsigned t;
        n = (count_reg > MAX_STOPS) ? MAX_STOPS : count_reg;
        if (n == 0) begin
            res = '{dflt, CASE_DEFAULT};
        end else if (z <= table_zoom[0]) begin
            res = '{table_value[0], CASE_BELOW};
        end else if (z > table_zoom[n-1]) begin
            res = '{table_value[n-1], CASE_ABOVE};
        end else begin
            res = '{table_value[n-1], CASE_NOSEG};
            for (int i = 0; i + 1 < n; i++) begin
                za = table_zoom[i];
                zb = table_zoom[i+1];
                if (za <= z && z < zb) begin
                    t = blend_fraction(longint'(z) - za, longint'(zb) - za);
                    res = '{blend_value(table_value[i], table_value[i+1], t), CASE_INTERP};
                    break;
                end
            end
        end
        return res;
    endfunction

    // Result side: stall at random, except while the quiet stretch runs.
    always @(negedge aclk)
        m_tready = aresetn && (quiet || $urandom_range(99) >= 28);

    always @(posedge aclk) begin
        lookup_t exp_res;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_lookups.size() == 0) begin
                $error("unexpected result transfer: value %h case %0d", m_tdata, m_tuser);
                mismatches++;
            end else begin
                exp_res = pending_lookups.pop_front();
                if (m_tdata !== exp_res.value) begin
                    $error("result_value: expected %h, got %h", exp_res.value, m_tdata);
                    mismatches++;
                end
                if (m_tuser !== exp_res.code) begin
                    $error("case_taken: expected %0d, got %0d", exp_res.code, m_tuser);
                    mismatches++;
                end
            end
        end
    end

    // One input transfer; the predictor is updated at the edge that accepts it.
    task automatic send_item(logic act, logic [3:0] slot, logic [23:0] sz, logic [31:0] sv,
                             logic [23:0] z, logic [31:0] dflt, bit typed = 1'b0,
                             logic [31:0] tv = '0, logic [2:0] tc = '0);
        @(negedge aclk);
        while (!quiet && $urandom_range(99) < 28) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tdata = {4'b0, dflt, z, sv, sz, slot};
        s_tuser = act;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        sent++;
        if (act == ACT_LOAD) begin
            table_zoom[slot] = sz;
            table_value[slot] = sv;
        end else if (typed) begin
            pending_lookups.push_back('{tv, tc});
        end else begin
            pending_lookups.push_back(predict_lookup(z, dflt));
        end
    endtask

    // Lets the core drain before anything else happens.
    task automatic drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_lookups.size() != 0) @(negedge aclk);
        // A load may still trail the last result; leave ample margin.
        repeat (20) @(negedge aclk);
    endtask

    task automatic write_reg(logic [1:0] sel, logic [23:0] data);
        drain();
        cfg_we = 1'b1;
        cfg_index = sel;
        cfg_wdata = data;
        @(negedge aclk);
        cfg_we = 1'b0;
        case (sel)
            CFG_BASE_LOG2:  base_reg = data;
            CFG_STOP_COUNT: count_reg = data[4:0];
            CFG_VALUE_MODE: mode_reg = data[0];
            default: ;
        endcase
    endtask

    function automatic row_t cfg_row(logic [1:0] sel, logic [23:0] data);
        row_t r;
        r = '{kind: ROW_CFG, default: '0};
        r.reg_sel = sel;
        r.reg_data = data;
        return r;
    endfunction

    function automatic row_t load_row(logic [3:0] slot, logic [23:0] sz, logic [31:0] sv);
        row_t r;
        r = '{kind: ROW_LOAD, default: '0};
        r.slot = slot;
        r.slot_zoom = sz;
        r.slot_value = sv;
        return r;
    endfunction

    function automatic row_t eval_row(logic [23:0] z, logic [31:0] dflt, bit typed = 1'b0,
                                      logic [31:0] tv = '0, logic [2:0] tc = '0);
        row_t r;
        r = '{kind: ROW_EVAL, default: '0};
        r.zoom = z;
        r.dflt = dflt;
        r.typed = typed;
        r.typed_value = tv;
        r.typed_code = tc;
        return r;
    endfunction

    // Loads all slots; sorted zooms most of the time so that lookups interpolate.
    task automatic load_all_slots(bit sorted);
        logic [23:0] z;
        z = 24'h800000 + $urandom_range(24'h0FFFFF);
        for (int i = 0; i < MAX_STOPS; i++) begin
            if (!sorted) z = $urandom();
            send_item(ACT_LOAD, i[3:0], z, $urandom(), $urandom(), $urandom());
            if ($urandom_range(1)) z = z + $urandom_range(1, 16);
            else z = z + $urandom_range(24'h0DFFFF);
        end
    endtask

    function automatic logic [23:0] pick_zoom();
        int          n, i;
        logic [23:0] span;
        n = (count_reg > MAX_STOPS) ? MAX_STOPS : count_reg;
        if (n == 0) return $urandom();
        i = $urandom_range(n - 1);
        case ($urandom_range(9))
            6: return table_zoom[i];
            7: return $urandom();
            8: return table_zoom[0] - $urandom_range(3);
            9: return table_zoom[n-1] + $urandom_range(3) - 1;
            default: begin
                if (n < 2) return table_zoom[0] + $urandom_range(7) - 3;
                i = $urandom_range(n - 2);
                span = table_zoom[i+1] - table_zoom[i];
                if ($signed(span) <= 0) return table_zoom[i];
                return table_zoom[i] + ($urandom() % span);
            end
        endcase
    endfunction

    function automatic logic [23:0] pick_base();
        case ($urandom_range(7))
            0, 1: return '0;
            2: return 24'h7FFFFF;
            3: return 24'h800000;
            4: return 24'd1;
            5: return $urandom_range(24'h3FFFFF) - 24'h200000;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [23:0] pick_count();
        case ($urandom_range(7))
            0: return 24'd0;
            1: return 24'd1;
            2: return 24'd16;
            3: return 24'd31;     // above the table depth, acts as a full table
            default: return $urandom_range(2, 16);
        endcase
    endfunction

    row_t directed [] = '{
        // No stops in use: the default value comes straight back.
        cfg_row(CFG_STOP_COUNT, 24'd0),
        eval_row(24'h800000, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF, CASE_DEFAULT),
        eval_row(24'h7FFFFF, 32'h00000000, 1'b1, 32'h00000000, CASE_DEFAULT),
        // Four stops; the third sits five units after the second.
        load_row(4'd0, 24'h800000, 32'h00000000),
        load_row(4'd1, 24'hFF0000, 32'hFFFFFFFF),
        load_row(4'd2, 24'hFF0005, 32'h7FFFFFFF),
        load_row(4'd15, 24'h400000, 32'h80000000),
        load_row(4'd3, 24'h400000, 32'h80000000),
        cfg_row(CFG_STOP_COUNT, 24'd4),
        eval_row(24'h800000, 32'h12345678, 1'b1, 32'h00000000, CASE_BELOW),
        eval_row(24'h7FFFFF, 32'h12345678, 1'b1, 32'h80000000, CASE_ABOVE),
        // Exactly on the last stop no segment matches.
        eval_row(24'h400000, 32'h12345678, 1'b1, 32'h80000000, CASE_NOSEG),
        eval_row(24'hFF0002, 32'h0),
        eval_row(24'h000000, 32'h0),
        // Smallest base: on the short segment the exponent vanishes and the linear fraction is used.
        cfg_row(CFG_BASE_LOG2, 24'd1),
        eval_row(24'hFF0003, 32'h0),
        eval_row(24'h100000, 32'h0),
        cfg_row(CFG_BASE_LOG2, 24'h7FFFFF),
        eval_row(24'h100000, 32'h0),
        eval_row(24'hC00000, 32'h0),
        cfg_row(CFG_BASE_LOG2, 24'h800000),
        eval_row(24'h100000, 32'h0),
        eval_row(24'hC00000, 32'h0),
        cfg_row(CFG_VALUE_MODE, 24'd1),
        eval_row(24'h200000, 32'h0),
        eval_row(24'hA00000, 32'h0),
        cfg_row(CFG_BASE_LOG2, 24'd0),
        eval_row(24'h000001, 32'h0)
    };

    initial begin
        int base_sent;
        longint unsigned f;
        f = 64'h8000_0000;
        for (int k = 0; k < EXP_TBITS; k++) begin
            f = floor_sqrt(f << 32);
            halving_fac[k] = f;
        end

        repeat (5) @(negedge aclk);
        aresetn = 1'b1;

        foreach (directed[i]) begin
            case (directed[i].kind)
                ROW_CFG:  write_reg(directed[i].reg_sel, directed[i].reg_data);
                ROW_LOAD: send_item(ACT_LOAD, directed[i].slot, directed[i].slot_zoom,
                                    directed[i].slot_value, $urandom(), $urandom());
                default:  send_item(ACT_EVAL, $urandom(), $urandom(), $urandom(),
                                    directed[i].zoom, directed[i].dflt, directed[i].typed,
                                    directed[i].typed_value, directed[i].typed_code);
            endcase
        end

        // Random phases: new settings while idle, then loads and lookups mixed.
        base_sent = sent;
        write_reg(CFG_STOP_COUNT, 24'd0);
        load_all_slots(1'b1);
        while (sent - base_sent < 750) begin
            write_reg(CFG_BASE_LOG2, pick_base());
            write_reg(CFG_STOP_COUNT, pick_count());
            write_reg(CFG_VALUE_MODE, $urandom_range(1));
            quiet = (sent - base_sent > 300 && sent - base_sent < 420);
            if ($urandom_range(2) == 0) load_all_slots($urandom_range(4) != 0);
            repeat (45) begin
                if ($urandom_range(9) == 0)
                    send_item(ACT_LOAD, $urandom(), $urandom(), $urandom(), $urandom(),
                              $urandom());
                else
                    send_item(ACT_EVAL, $urandom(), $urandom(), $urandom(), pick_zoom(),
                              $urandom());
            end
        end
        quiet = 1'b0;

        drain();
        repeat (200) @(posedge aclk);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #50ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
